@@ hw/rtl/ohb_pkg.sv @@
// Shared types and constants for the overwrite-oldest history buffer.
// Depends on nothing; every other file in the block imports it.
package ohb_pkg;

   // Command codes carried on the action field of an input item.
   localparam logic [2:0] ACT_APPEND = 3'd0;
   localparam logic [2:0] ACT_NEXT   = 3'd1;
   localparam logic [2:0] ACT_PREV   = 3'd2;
   localparam logic [2:0] ACT_CLEAR  = 3'd3;
   localparam logic [2:0] ACT_VIEW   = 3'd4;

   // Reported position and fill are five bits wide.
   localparam int unsigned REPORT_W = 5;

   // One stored record: the tag and the readings side by side.
   typedef struct packed {
      logic [9:0]         sensor;
      logic signed [11:0] temperature;
      logic [9:0]         humidity;
      logic [16:0]        pressure;
      logic [15:0]        vibration;
      logic [31:0]        stamp;
   } record_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic exec;      // update ring pointers and write the store
      logic read;      // read the record under the cursor
   } cmd_type;

endpackage

@@ hw/rtl/overwrite_oldest_history_buffer.sv @@
// Overwrite-oldest history buffer with a browse cursor.
// An accepted item passes through the execute and store-read states before its result
// is valid. The next item is accepted only after the result is taken, since the
// controller holds one item.
// Reset: synchronous, clears the ring pointers, fill count and handshake; the store is
// not cleared, since a read result is passed out only while the buffer holds records.
module overwrite_oldest_history_buffer
   import ohb_pkg::*;
#(
   parameter int unsigned LOG_DEPTH = 20
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_action,
   input  logic [9:0]          req_sensor_id,
   input  logic signed [11:0]  req_temperature,
   input  logic [9:0]          req_humidity,
   input  logic [16:0]         req_pressure,
   input  logic [15:0]         req_vibration,
   input  logic [31:0]         req_stamp,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_entry_valid,
   output logic [9:0]          rsp_cur_sensor,
   output logic signed [11:0]  rsp_cur_temperature,
   output logic [9:0]          rsp_cur_humidity,
   output logic [16:0]         rsp_cur_pressure,
   output logic [15:0]         rsp_cur_vibration,
   output logic [31:0]         rsp_cur_stamp,
   output logic [4:0]          rsp_position,
   output logic [4:0]          rsp_fill,
   output logic                rsp_refused
);

   cmd_type    cmd;
   record_type in_rec;
   record_type out_rec;

   // Pack the incoming item into one record.
   assign in_rec.sensor      = req_sensor_id;
   assign in_rec.temperature = req_temperature;
   assign in_rec.humidity    = req_humidity;
   assign in_rec.pressure    = req_pressure;
   assign in_rec.vibration   = req_vibration;
   assign in_rec.stamp       = req_stamp;

   ohb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ohb_dpath #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .in_action       (req_action),
      .in_record       (in_rec),
      .out_entry_valid (rsp_entry_valid),
      .out_record      (out_rec),
      .out_position    (rsp_position),
      .out_fill        (rsp_fill),
      .out_refused     (rsp_refused)
   );

   // Unpack the record under the cursor.
   assign rsp_cur_sensor      = out_rec.sensor;
   assign rsp_cur_temperature = out_rec.temperature;
   assign rsp_cur_humidity    = out_rec.humidity;
   assign rsp_cur_pressure    = out_rec.pressure;
   assign rsp_cur_vibration   = out_rec.vibration;
   assign rsp_cur_stamp       = out_rec.stamp;

endmodule

@@ hw/rtl/ohb_ctrl.sv @@
// Controller state machine of the history buffer.
// Depends on ohb_pkg; drives the datapath commands and both handshakes.
module ohb_ctrl
   import ohb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   // Sequence one item through execute, read and respond.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready   = req_ready_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = req_valid & req_ready_ff;
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign cmd.read    = (state_ff == ST_READ);

endmodule

@@ hw/rtl/ohb_dpath.sv @@
// Datapath of the history buffer: ring pointers, record store, result registers.
// Depends on ohb_pkg; steered by the commands of ohb_ctrl.
module ohb_dpath
   import ohb_pkg::*;
#(
   parameter int unsigned LOG_DEPTH = 20
)(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [2:0]          in_action,
   input  record_type          in_record,
   output logic                out_entry_valid,
   output record_type          out_record,
   output logic [REPORT_W-1:0] out_position,
   output logic [REPORT_W-1:0] out_fill,
   output logic                out_refused
);

   localparam int unsigned IW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(LOG_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(LOG_DEPTH);

   // Ring state.
   logic [IW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] held_ff, held_in;
   logic [IW-1:0] cursor_ff, cursor_in;
   logic          refused_ff, refused_in;

   // Captured item and result registers.
   logic [2:0]    act_ff;
   record_type    rec_ff;
   record_type    rd_ff;
   logic          entry_ff;
   logic [CW-1:0] pos_ff;

   // Record store, written on append and read once per item.
   record_type    store [LOG_DEPTH];

   logic          wr_en;
   logic [IW-1:0] wr_slot;
   logic [IW-1:0] offset;

   // Slot one step forward or back around the ring.
   function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] s);
      return (s == '0) ? LAST_SLOT : s - 1'b1;
   endfunction

   // Distance of the cursor from the oldest record.
   always_comb begin
      if (cursor_ff >= oldest_ff) begin
         offset = cursor_ff - oldest_ff;
      end else begin
         offset = IW'((IW + 1)'(cursor_ff) + (IW + 1)'(LOG_DEPTH) - (IW + 1)'(oldest_ff));
      end
   end

   // Next ring state for the captured command.
   always_comb begin
      logic [IW-1:0] oldest_a;
      logic [CW-1:0] held_a;
      logic [IW-1:0] cursor_a;
      logic [CW:0]   sum;
      oldest_in  = oldest_ff;
      held_in    = held_ff;
      cursor_in  = cursor_ff;
      refused_in = 1'b0;
      wr_en      = 1'b0;
      oldest_a   = oldest_ff;
      held_a     = held_ff;
      cursor_a   = cursor_ff;
      sum        = '0;
      wr_slot    = '0;
      unique case (act_ff)
         ACT_APPEND: begin
            // A full ring drops its oldest record first.
            if (held_ff >= FULL_COUNT) begin
               oldest_a = slot_inc(oldest_ff);
               held_a   = held_ff - 1'b1;
               if (cursor_ff == oldest_ff) begin
                  cursor_a = oldest_a;
               end
            end
            sum = (CW + 1)'(oldest_a) + (CW + 1)'(held_a);
            if (sum >= (CW + 1)'(LOG_DEPTH)) begin
               sum = sum - (CW + 1)'(LOG_DEPTH);
            end
            wr_slot = IW'(sum);
            if (held_a == '0) begin
               cursor_a = wr_slot;
            end
            wr_en     = 1'b1;
            oldest_in = oldest_a;
            held_in   = held_a + 1'b1;
            cursor_in = cursor_a;
         end
         ACT_NEXT: begin
            if (held_ff != '0 && (CW'(offset) + 1'b1) < held_ff) begin
               cursor_in = slot_inc(cursor_ff);
            end else begin
               refused_in = 1'b1;
            end
         end
         ACT_PREV: begin
            if (held_ff != '0 && offset != '0) begin
               cursor_in = slot_dec(cursor_ff);
            end else begin
               refused_in = 1'b1;
            end
         end
         ACT_CLEAR: begin
            oldest_in = '0;
            held_in   = '0;
            cursor_in = '0;
         end
         default: begin
            // View only, and the unused codes behave the same.
         end
      endcase
   end

   // Ring pointers, the refusal flag and the entry flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff  <= '0;
         held_ff    <= '0;
         cursor_ff  <= '0;
         refused_ff <= 1'b0;
         entry_ff   <= 1'b0;
      end else begin
         if (cmd.exec) begin
            oldest_ff  <= oldest_in;
            held_ff    <= held_in;
            cursor_ff  <= cursor_in;
            refused_ff <= refused_in;
         end
         if (cmd.read) begin
            entry_ff <= (held_ff != '0);
         end
      end
   end

   // Item capture and result payload.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= in_action;
         rec_ff <= in_record;
      end
      if (cmd.read) begin
         pos_ff <= CW'(offset) + 1'b1;
      end
   end

   // Store write on append, registered read at the cursor.
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         store[wr_slot] <= rec_ff;
      end
      if (cmd.read) begin
         rd_ff <= store[cursor_ff];
      end
   end

   // An empty buffer reports zeros for the record and its position.
   always_comb begin
      logic [CW+REPORT_W-1:0] pos_ext;
      logic [CW+REPORT_W-1:0] fill_ext;
      pos_ext         = (CW + REPORT_W)'(pos_ff);
      fill_ext        = (CW + REPORT_W)'(held_ff);
      out_entry_valid = entry_ff;
      out_record      = entry_ff ? rd_ff : '0;
      out_position    = entry_ff ? pos_ext[REPORT_W-1:0] : '0;
      out_fill        = fill_ext[REPORT_W-1:0];
      out_refused     = refused_ff;
   end

endmodule

@@ hw/rtl/ohb_checker.sv @@
// Port-level checker for the history buffer and its bind to the top level.
// Depends on ohb_pkg and on the top level's port list.
module ohb_checker
   import ohb_pkg::*;
#(
   parameter int unsigned LOG_DEPTH = 20
)(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_entry_valid,
   input logic [31:0] rsp_cur_stamp,
   input logic [4:0] rsp_position,
   input logic [4:0] rsp_fill
);

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fill) && $stable(rsp_position)
         && $stable(rsp_cur_stamp))
      else $error("stalled result changed");

   // Only one item is in flight: acceptance closes the input side.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in flight");

   // The input side stays closed while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input open while a result is pending");

   // An empty report carries no record and no position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> rsp_position == '0 && rsp_cur_stamp == '0)
      else $error("empty buffer reported a record");

   // A valid cursor lies within the held records when the count fits the field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid && (LOG_DEPTH < 32) |->
         rsp_position != '0 && rsp_position <= rsp_fill)
      else $error("cursor position outside the held records");

endmodule

bind overwrite_oldest_history_buffer ohb_checker #(
   .LOG_DEPTH (LOG_DEPTH)
) u_ohb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_entry_valid (rsp_entry_valid),
   .rsp_cur_stamp   (rsp_cur_stamp),
   .rsp_position    (rsp_position),
   .rsp_fill        (rsp_fill)
);
